// File: design/utf8d_pkg.sv
// utf8d_pkg: shared types and constants for the utf8 code point decoder
// used by utf8_code_point_decoder and utf8d_checker; no dependencies
package utf8d_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CP_W         = 21;
    localparam int unsigned IDX_OUT_W    = 16;
    localparam int unsigned WIDTH_W      = 3;
    localparam int unsigned REM_W        = 2;
    localparam int unsigned INDEX_BITS_DEF = 16;

    // byte widths announced by a lead byte
    localparam logic [WIDTH_W-1:0] WIDTH_ONE   = 3'd1;
    localparam logic [WIDTH_W-1:0] WIDTH_TWO   = 3'd2;
    localparam logic [WIDTH_W-1:0] WIDTH_THREE = 3'd3;
    localparam logic [WIDTH_W-1:0] WIDTH_FOUR  = 3'd4;

    // lead byte class masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              string_end;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]      cp_value;
        logic [IDX_OUT_W-1:0] sym_pos;
        logic [WIDTH_W-1:0]   sym_bytes;
        logic                 truncated;
        logic                 last_of_string;
    } t_out_item;

endpackage

// File: design/utf8_code_point_decoder.sv
// utf8_code_point_decoder: byte-serial utf8 decoder, one byte per cycle while the output is not stalled
// depends on utf8d_pkg (transaction structs, lead byte constants)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//
// one byte transaction per cycle sustained while the result is not stalled, set by the single decode stage
// a byte waits in the input register until the output register is free; a result
// that completes a symbol is registered in the output register as the byte leaves it
// decode state (remaining bytes, partial value, width, count) updates as a
// byte leaves the input register; reset clears both valid flags and the state
// a stalled result holds; the input register still drains when it is taken
module utf8_code_point_decoder #(
    parameter int unsigned INDEX_BITS = utf8d_pkg::INDEX_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  utf8d_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output utf8d_pkg::t_out_item o_out_data
);

    // input register
    logic                 r_in_vld;
    logic                 n_in_vld;
    utf8d_pkg::t_in_item  r_in;

    // result register
    logic                 r_out_vld;
    logic                 n_out_vld;
    utf8d_pkg::t_out_item r_out;
    utf8d_pkg::t_out_item n_out;

    // decode state
    logic [utf8d_pkg::REM_W-1:0]   r_rem;
    logic [utf8d_pkg::REM_W-1:0]   n_rem;
    logic [utf8d_pkg::CP_W-1:0]    r_part;
    logic [utf8d_pkg::CP_W-1:0]    n_part;
    logic [utf8d_pkg::WIDTH_W-1:0] r_cw;
    logic [utf8d_pkg::WIDTH_W-1:0] n_cw;
    logic [INDEX_BITS-1:0]         r_count;
    logic [INDEX_BITS-1:0]         n_count;

    logic                          out_free;
    logic                          fire;
    logic                          in_acc;
    logic                          emit;
    logic [utf8d_pkg::WIDTH_W-1:0] lead_w;
    logic [utf8d_pkg::CP_W-1:0]    lead_bits;
    logic [utf8d_pkg::CP_W-1:0]    shifted;
    logic [utf8d_pkg::REM_W-1:0]   rem_dec;
    logic [INDEX_BITS-1:0]         count_adv;
    logic [utf8d_pkg::IDX_OUT_W-1:0] idx_out;

    // the output register frees up when empty or taken this cycle
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // symbol index clamped to the output width
    generate
        if (INDEX_BITS > utf8d_pkg::IDX_OUT_W) begin : g_clamp
            assign idx_out = (|r_count[INDEX_BITS-1:utf8d_pkg::IDX_OUT_W])
                           ? {utf8d_pkg::IDX_OUT_W{1'b1}}
                           : r_count[utf8d_pkg::IDX_OUT_W-1:0];
        end else begin : g_ext
            assign idx_out = utf8d_pkg::IDX_OUT_W'(r_count);
        end
    endgenerate

    // saturating count, restarts after the last byte of a string
    always_comb begin
        if (r_in.string_end) begin
            count_adv = '0;
        end else if (&r_count) begin
            count_adv = r_count;
        end else begin
            count_adv = r_count + INDEX_BITS'(1);
        end
    end

    // lead byte classification
    always_comb begin
        if ((r_in.data_byte & utf8d_pkg::ASCII_MASK) == '0) begin
            lead_w    = utf8d_pkg::WIDTH_ONE;
            lead_bits = utf8d_pkg::CP_W'(r_in.data_byte[6:0]);
        end else if ((r_in.data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
            lead_w    = utf8d_pkg::WIDTH_TWO;
            lead_bits = utf8d_pkg::CP_W'(r_in.data_byte[4:0]);
        end else if ((r_in.data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
            lead_w    = utf8d_pkg::WIDTH_THREE;
            lead_bits = utf8d_pkg::CP_W'(r_in.data_byte[3:0]);
        end else begin
            // stray continuation bytes and 11111xxx land here too
            lead_w    = utf8d_pkg::WIDTH_FOUR;
            lead_bits = utf8d_pkg::CP_W'(r_in.data_byte[2:0]);
        end
    end

    // continuation bytes are not checked, low six bits shift in
    assign shifted = {r_part[utf8d_pkg::CP_W-7:0], r_in.data_byte[5:0]};
    assign rem_dec = r_rem - utf8d_pkg::REM_W'(1);

    // per-byte decode step
    always_comb begin
        emit    = 1'b0;
        n_out   = r_out;
        n_rem   = r_rem;
        n_part  = r_part;
        n_cw    = r_cw;
        n_count = r_count;
        if (r_rem == '0) begin
            if (lead_w == utf8d_pkg::WIDTH_ONE) begin
                emit                 = 1'b1;
                n_out.cp_value       = lead_bits;
                n_out.sym_pos        = idx_out;
                n_out.sym_bytes      = lead_w;
                n_out.truncated      = 1'b0;
                n_out.last_of_string = r_in.string_end;
                n_count              = count_adv;
            end else if (r_in.string_end) begin
                // string ended right after a multi-byte lead
                emit                 = 1'b1;
                n_out.cp_value       = '0;
                n_out.sym_pos        = idx_out;
                n_out.sym_bytes      = lead_w;
                n_out.truncated      = 1'b1;
                n_out.last_of_string = 1'b1;
                n_rem                = '0;
                n_part               = '0;
                n_cw                 = '0;
                n_count              = '0;
            end else begin
                n_part = lead_bits;
                n_cw   = lead_w;
                n_rem  = utf8d_pkg::REM_W'(lead_w - utf8d_pkg::WIDTH_ONE);
            end
        end else begin
            if (rem_dec == '0) begin
                emit                 = 1'b1;
                n_out.cp_value       = shifted;
                n_out.sym_pos        = idx_out;
                n_out.sym_bytes      = r_cw;
                n_out.truncated      = 1'b0;
                n_out.last_of_string = r_in.string_end;
                n_rem                = '0;
                n_part               = '0;
                n_cw                 = '0;
                n_count              = count_adv;
            end else if (r_in.string_end) begin
                // string ended inside a sequence, partial symbol dropped
                emit                 = 1'b1;
                n_out.cp_value       = '0;
                n_out.sym_pos        = idx_out;
                n_out.sym_bytes      = r_cw;
                n_out.truncated      = 1'b1;
                n_out.last_of_string = 1'b1;
                n_rem                = '0;
                n_part               = '0;
                n_cw                 = '0;
                n_count              = '0;
            end else begin
                n_part = shifted;
                n_rem  = rem_dec;
            end
        end
    end

    // valid flag next values
    always_comb begin
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
        if (fire) begin
            n_out_vld = emit;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_rem     <= '0;
            r_part    <= '0;
            r_cw      <= '0;
            r_count   <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (fire) begin
                r_rem   <= n_rem;
                r_part  <= n_part;
                r_cw    <= n_cw;
                r_count <= n_count;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

endmodule

// File: design/utf8d_checker.sv
// utf8d_checker: port-level assertions for utf8_code_point_decoder
// depends on utf8d_pkg; bound into utf8_code_point_decoder at the end of this file
module utf8d_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input utf8d_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input utf8d_pkg::t_out_item o_out_data
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // truncated results carry zero, close the string and are never single-byte
    a_trunc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.truncated |->
            o_out_data.cp_value == '0 && o_out_data.last_of_string
            && o_out_data.sym_bytes != utf8d_pkg::WIDTH_ONE)
        else $error("bad truncated result");

    // byte width stays within one to four
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            o_out_data.sym_bytes == utf8d_pkg::WIDTH_ONE
            || o_out_data.sym_bytes == utf8d_pkg::WIDTH_TWO
            || o_out_data.sym_bytes == utf8d_pkg::WIDTH_THREE
            || o_out_data.sym_bytes == utf8d_pkg::WIDTH_FOUR)
        else $error("byte width out of range");

    // single byte symbols are seven bit values
    a_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sym_bytes == utf8d_pkg::WIDTH_ONE |->
            o_out_data.cp_value[utf8d_pkg::CP_W-1:7] == '0)
        else $error("single byte symbol too wide");

endmodule

bind utf8_code_point_decoder utf8d_checker u_utf8d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: bench/tb_utf8_code_point_decoder.sv
// tb_utf8_code_point_decoder: self-checking bench for the utf8 code point decoder
// depends on utf8d_pkg and utf8_code_point_decoder; drives bytes, predicts and
// compares every decoded symbol against a local decode model
module tb_utf8_code_point_decoder;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [utf8d_pkg::IDX_OUT_W-1:0] INDEX_MAX = '1;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    utf8d_pkg::t_in_item  i_in_data  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    utf8d_pkg::t_out_item o_out_data;

    utf8_code_point_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // idle chances in percent, per side
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // long receiver hold-off: the stimulus bumps the request count and the
    // receiver process counts the hold down on its own
    int hold_req_seq = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    int cycle_count    = 0;
    int error_count    = 0;
    int reported_count = 0;

    // decode state of the local model
    logic [utf8d_pkg::REM_W-1:0]     dec_remaining = '0;
    logic [utf8d_pkg::CP_W-1:0]      dec_partial   = '0;
    logic [utf8d_pkg::WIDTH_W-1:0]   dec_width     = '0;
    logic [utf8d_pkg::IDX_OUT_W-1:0] dec_count     = '0;

    // decoded symbols waiting for the block to produce them
    utf8d_pkg::t_out_item pending_symbols[$];

    // clock
    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // run limit: a cycle counter that ends a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // local decode model --------------------------------------------------

    function automatic void push_symbol(input logic [utf8d_pkg::CP_W-1:0] cp,
                                        input logic [utf8d_pkg::WIDTH_W-1:0] w,
                                        input logic trunc, input logic last);
        utf8d_pkg::t_out_item r;
        r.cp_value       = cp;
        r.sym_pos        = dec_count;
        r.sym_bytes      = w;
        r.truncated      = trunc;
        r.last_of_string = last;
        pending_symbols.insert(pending_symbols.size(), r);
    endfunction

    // symbol counter restarts after the last byte, otherwise saturates
    function automatic void advance_symbol_count(input logic last);
        if (last) begin
            dec_count = '0;
        end else if (dec_count != INDEX_MAX) begin
            dec_count = dec_count + 1'b1;
        end
    endfunction

    function automatic void clear_decode_state();
        dec_remaining = '0;
        dec_partial   = '0;
        dec_width     = '0;
        dec_count     = '0;
    endfunction

    function automatic void decode_byte(input utf8d_pkg::t_in_item it);
        logic [utf8d_pkg::WIDTH_W-1:0] w;
        logic [utf8d_pkg::CP_W-1:0]    bits;
        if (dec_remaining == '0) begin
            // lead byte: classify by its top bits
            if ((it.data_byte & utf8d_pkg::ASCII_MASK) == '0) begin
                w    = utf8d_pkg::WIDTH_ONE;
                bits = utf8d_pkg::CP_W'(it.data_byte);
            end else if ((it.data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
                w    = utf8d_pkg::WIDTH_TWO;
                bits = utf8d_pkg::CP_W'(it.data_byte[4:0]);
            end else if ((it.data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
                w    = utf8d_pkg::WIDTH_THREE;
                bits = utf8d_pkg::CP_W'(it.data_byte[3:0]);
            end else begin
                // stray continuation and 11111xxx fall in here too
                w    = utf8d_pkg::WIDTH_FOUR;
                bits = utf8d_pkg::CP_W'(it.data_byte[2:0]);
            end
            if (w == utf8d_pkg::WIDTH_ONE) begin
                push_symbol(bits, utf8d_pkg::WIDTH_ONE, 1'b0, it.string_end);
                advance_symbol_count(it.string_end);
            end else if (it.string_end) begin
                push_symbol('0, w, 1'b1, 1'b1);
                clear_decode_state();
            end else begin
                dec_partial   = bits;
                dec_width     = w;
                dec_remaining = utf8d_pkg::REM_W'(w - 1'b1);
            end
        end else begin
            // continuation: low six bits shifted in, top bits ignored
            dec_partial   = {dec_partial[utf8d_pkg::CP_W-7:0], it.data_byte[5:0]};
            dec_remaining = dec_remaining - 1'b1;
            if (dec_remaining == '0) begin
                push_symbol(dec_partial, dec_width, 1'b0, it.string_end);
                dec_partial = '0;
                advance_symbol_count(it.string_end);
                dec_width = '0;
            end else if (it.string_end) begin
                push_symbol('0, dec_width, 1'b1, 1'b1);
                clear_decode_state();
            end
        end
    endfunction

    // receiver side -------------------------------------------------------

    always @(posedge i_clk) begin
        if (hold_req_seq != hold_seen) begin
            hold_seen   <= hold_req_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // result checker: every output transaction against the oldest prediction
    always @(posedge i_clk) begin
        utf8d_pkg::t_out_item exp_sym;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_symbols.size() == 0) begin
                error_count++;
                if (reported_count < MAX_REPORTS) begin
                    reported_count++;
                    $display("unexpected symbol: cp=%h idx=%0d w=%0d trunc=%b last=%b",
                             o_out_data.cp_value, o_out_data.sym_pos,
                             o_out_data.sym_bytes, o_out_data.truncated,
                             o_out_data.last_of_string);
                end
            end else begin
                exp_sym = pending_symbols.pop_front();
                if (o_out_data.cp_value       !== exp_sym.cp_value  ||
                    o_out_data.sym_pos        !== exp_sym.sym_pos   ||
                    o_out_data.sym_bytes      !== exp_sym.sym_bytes ||
                    o_out_data.truncated      !== exp_sym.truncated ||
                    o_out_data.last_of_string !== exp_sym.last_of_string) begin
                    error_count++;
                    if (reported_count < MAX_REPORTS) begin
                        reported_count++;
                        $display("symbol mismatch: expected cp=%h idx=%0d w=%0d trunc=%b last=%b",
                                 exp_sym.cp_value, exp_sym.sym_pos,
                                 exp_sym.sym_bytes, exp_sym.truncated,
                                 exp_sym.last_of_string);
                        $display("                 actual   cp=%h idx=%0d w=%0d trunc=%b last=%b",
                                 o_out_data.cp_value, o_out_data.sym_pos,
                                 o_out_data.sym_bytes, o_out_data.truncated,
                                 o_out_data.last_of_string);
                    end
                end
            end
        end
    end

    // sender side ---------------------------------------------------------

    // offer one byte, wait for its transaction, then predict its symbol;
    // valid stays high for a back-to-back byte
    task automatic send_byte(input logic [utf8d_pkg::BYTE_W-1:0] b, input logic last);
        utf8d_pkg::t_in_item it;
        it.data_byte  = b;
        it.string_end = last;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        decode_byte(it);
    endtask

    // sender pauses until every predicted symbol has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_symbols.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // tests ---------------------------------------------------------------

    // lowest and highest single-byte symbols, the second ends the string
    task automatic test_ascii_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // well-formed two, three and four byte symbols in one string
    task automatic test_multibyte_symbols();
        send_byte(8'hC2, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // stray continuation and 11111xxx leads both announce four bytes;
    // continuations with odd top bits still contribute their low bits
    task automatic test_odd_leads_and_continuations();
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // string ends on a lead byte and in the middle of a sequence
    task automatic test_truncated_strings();
        send_byte(8'hC2, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b1);
    endtask

    // random strings: mostly well-formed symbols with random content,
    // some noise bytes and some strings cut off inside a symbol
    task automatic test_random_strings(input int byte_budget, input logic with_hold);
        logic [utf8d_pkg::BYTE_W-1:0] str_bytes[$];
        int sent;
        int nsym;
        int kind;
        int w;
        int keep;
        sent = 0;
        if (with_hold) begin
            hold_req_seq <= hold_req_seq + 1;
        end
        while (sent < byte_budget) begin
            str_bytes.delete();
            nsym = $urandom_range(1, 12);
            for (int s = 0; s < nsym; s++) begin
                kind = $urandom_range(0, 99);
                if (kind < 85) begin
                    w = $urandom_range(1, 4);
                    case (w)
                        1: str_bytes.insert(str_bytes.size(),
                               utf8d_pkg::BYTE_W'($urandom_range(0, 127)));
                        2: str_bytes.insert(str_bytes.size(),
                               8'hC0 | utf8d_pkg::BYTE_W'($urandom_range(0, 31)));
                        3: str_bytes.insert(str_bytes.size(),
                               8'hE0 | utf8d_pkg::BYTE_W'($urandom_range(0, 15)));
                        default: begin
                            // four byte lead, sometimes an irregular one
                            if ($urandom_range(0, 3) == 0) begin
                                str_bytes.insert(str_bytes.size(), $urandom_range(0, 1) ?
                                    (8'h80 | utf8d_pkg::BYTE_W'($urandom_range(0, 63))) :
                                    (8'hF8 | utf8d_pkg::BYTE_W'($urandom_range(0, 7))));
                            end else begin
                                str_bytes.insert(str_bytes.size(),
                                    8'hF0 | utf8d_pkg::BYTE_W'($urandom_range(0, 7)));
                            end
                        end
                    endcase
                    for (int c = 1; c < w; c++) begin
                        str_bytes.insert(str_bytes.size(),
                            8'h80 | utf8d_pkg::BYTE_W'($urandom_range(0, 63)));
                    end
                end else begin
                    // noise byte, may throw the sequence framing off
                    str_bytes.insert(str_bytes.size(),
                        utf8d_pkg::BYTE_W'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 99) < 15) begin
                // cut-off tail: a lead and fewer continuations than it announced
                w = $urandom_range(2, 4);
                str_bytes.insert(str_bytes.size(),
                    w == 2 ? (8'hC0 | utf8d_pkg::BYTE_W'($urandom_range(0, 31))) :
                    w == 3 ? (8'hE0 | utf8d_pkg::BYTE_W'($urandom_range(0, 15))) :
                             (8'hF0 | utf8d_pkg::BYTE_W'($urandom_range(0, 7))));
                keep = $urandom_range(0, w - 2);
                for (int c = 0; c < keep; c++) begin
                    str_bytes.insert(str_bytes.size(),
                        8'h80 | utf8d_pkg::BYTE_W'($urandom_range(0, 63)));
                end
            end
            foreach (str_bytes[k]) begin
                send_byte(str_bytes[k], k == str_bytes.size() - 1);
            end
            sent += str_bytes.size();
        end
    endtask

    // stimulus ------------------------------------------------------------

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        clear_decode_state();
        @(posedge i_clk);

        // sender idles rarely, receiver stalls often
        set_idling(11, 67);
        test_ascii_extremes();
        test_multibyte_symbols();
        test_odd_leads_and_continuations();
        test_truncated_strings();
        wait_drained();
        test_random_strings(460, 1'b0);
        wait_drained();

        // the other way round
        set_idling(67, 11);
        test_random_strings(460, 1'b0);
        wait_drained();

        // no idling; a long receiver hold fills the block and stalls input
        set_idling(0, 0);
        test_random_strings(460, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_symbols.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
